@@ design/wsd_pkg.sv @@
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared codes, widths and types of the work-stealing task dispatcher.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int WID_W  = 6;   // worker index field
  localparam int CNT_W  = 7;   // worker counts
  localparam int TASK_W = 16;  // task handle
  localparam int CFG_AW = 1;
  localparam int CFG_DW = 7;

  typedef enum logic [2:0] {
    MODE_SUBMIT    = 3'd0,
    MODE_TAKE      = 3'd1,
    MODE_COMPLETE  = 3'd2,
    MODE_BLK_BEGIN = 3'd3,
    MODE_BLK_END   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_NONE  = 2'd3
  } status_t;

  localparam logic [CFG_AW-1:0] REG_INIT_WORKERS = 1'b0;
  localparam logic [CFG_AW-1:0] REG_POOL_STARTED = 1'b1;

  // Control strobes from the sequencer to the queue storage
  typedef struct packed {
    logic meta_rd;
    logic meta_wr;
    logic store_rd;
    logic store_wr;
  } qctl_t;

endpackage

@@ design/wsd_rem_unit.sv @@
// ----------------------------------------------------------------------------
// wsd_rem_unit
// Bit-serial remainder of a worker index by the active worker count.
// ----------------------------------------------------------------------------
module wsd_rem_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [wsd_pkg::WID_W-1:0] dividend,
  input  logic [wsd_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [wsd_pkg::WID_W-1:0] rem
);
  import wsd_pkg::*;

  localparam int STEP_W = $clog2(WID_W + 1);

  logic [CNT_W-1:0]  part;
  logic [WID_W-1:0]  bits;
  logic [STEP_W-1:0] steps;
  logic [CNT_W-1:0]  trial;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {part[WID_W-1:0], bits[WID_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= !go && (steps == STEP_W'(1));
      if (go) begin
        steps <= STEP_W'(WID_W);
        part  <= '0;
        bits  <= dividend;
      end else if (steps != '0) begin
        part  <= (trial >= divisor) ? trial - divisor : trial;
        bits  <= {bits[WID_W-2:0], 1'b0};
        steps <= steps - 1'b1;
      end
    end
  end

  assign rem = part[WID_W-1:0];

endmodule

@@ design/wsd_queues.sv @@
// ----------------------------------------------------------------------------
// wsd_queues
// Per-worker FIFO storage: task memory, head/fill memory and non-empty map.
// ----------------------------------------------------------------------------
module wsd_queues #(
  parameter int MAX_WORKERS = 64,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  wsd_pkg::qctl_t              ctl,
  input  logic [$clog2(MAX_WORKERS)-1:0] meta_addr,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_head,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] wr_fill,
  input  logic [$clog2(MAX_WORKERS*QUEUE_DEPTH)-1:0] store_addr,
  input  logic [wsd_pkg::TASK_W-1:0]  store_wdata,
  output logic [$clog2(QUEUE_DEPTH)-1:0] rd_head,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] rd_fill,
  output logic [wsd_pkg::TASK_W-1:0]  store_rdata,
  output logic [MAX_WORKERS-1:0]      nonempty
);
  import wsd_pkg::*;

  localparam int HW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int SD = MAX_WORKERS * QUEUE_DEPTH;

  logic [HW+FW-1:0]      meta_mem [MAX_WORKERS];
  logic [MAX_WORKERS-1:0] meta_valid;
  logic [HW+FW-1:0]      meta_q;
  logic                  meta_q_valid;
  logic [TASK_W-1:0]     store_mem [SD];

  always_ff @(posedge clk) begin
    if (ctl.meta_wr) begin
      meta_mem[meta_addr] <= {wr_head, wr_fill};
    end
    if (ctl.meta_rd) begin
      meta_q       <= meta_mem[meta_addr];
      meta_q_valid <= meta_valid[meta_addr];
    end
    if (ctl.store_wr) begin
      store_mem[store_addr] <= store_wdata;
    end
    if (ctl.store_rd) begin
      store_rdata <= store_mem[store_addr];
    end
  end

  // Entries never written read as an empty queue at head zero
  always_ff @(posedge clk) begin
    if (rst) begin
      meta_valid <= '0;
      nonempty   <= '0;
    end else if (ctl.meta_wr) begin
      meta_valid[meta_addr] <= 1'b1;
      nonempty[meta_addr]   <= (wr_fill != '0);
    end
  end

  assign rd_head = meta_q_valid ? meta_q[HW+FW-1:FW] : '0;
  assign rd_fill = meta_q_valid ? meta_q[FW-1:0] : '0;

endmodule

@@ design/work_stealing_task_dispatcher_top.sv @@
// ----------------------------------------------------------------------------
// work_stealing_task_dispatcher_top
// Round-robin task submission to per-worker FIFOs with stealing on take.
// ----------------------------------------------------------------------------
// Items enter on start while busy is low; each item gives one result, shown
// for one cycle with done, and the receiver cannot stall it. A new item is
// accepted only once the current one is back in idle. A submit passes the
// queue state read, then the write, the result and the return to idle. A
// take first runs the bit-serial remainder that wraps worker onto the active
// count (six steps and its done cycle), then the priority search over the
// non-empty map, the queue state and task memory reads, the result and the
// return to idle; a take that finds no task skips the reads. Complete, block
// and unused-mode items go straight to the result and back to idle.
// Configuration writes are taken at any clock edge and must only be made while
// no item is in flight.
module work_stealing_task_dispatcher_top #(
  parameter int MAX_WORKERS = 64,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [wsd_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [wsd_pkg::CFG_DW-1:0] cfg_data,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 mode,
  input  logic [5:0]                 worker,
  input  logic [15:0]                task_id,
  output logic                       done,
  output logic [1:0]                 status,
  output logic [15:0]                task_out,
  output logic [5:0]                 source_queue,
  output logic                       stolen,
  output logic                       spawned,
  output logic [10:0]                pending_count,
  output logic [6:0]                 busy_count,
  output logic [6:0]                 blocked_count,
  output logic [6:0]                 worker_count,
  output logic [31:0]                completed_count
);
  import wsd_pkg::*;

  localparam int WI = $clog2(MAX_WORKERS);
  localparam int HW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(MAX_WORKERS * QUEUE_DEPTH);
  localparam int PW = $clog2(MAX_WORKERS * QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] MAXW = CNT_W'(MAX_WORKERS);
  localparam logic [CNT_W-1:0] RST_WORKERS = (MAX_WORKERS < 4) ? MAXW : CNT_W'(4);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_REM  = 7'b0000010,
    S_SCAN = 7'b0000100,
    S_META = 7'b0001000,
    S_CHK  = 7'b0010000,
    S_DATA = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic              pool_started;
  logic [CNT_W-1:0]  active_workers;
  logic [WID_W-1:0]  next_target;
  logic [PW-1:0]     pending_tasks;
  logic [CNT_W-1:0]  busy_workers;
  logic [CNT_W-1:0]  blocked_workers;
  logic [MAX_WORKERS-1:0] blocked_mark;
  logic [31:0]       completed_tasks;

  mode_t             cur_mode;
  logic [TASK_W-1:0] cur_tid;
  logic [WID_W-1:0]  own;
  logic [WID_W-1:0]  target;

  qctl_t             qctl;
  logic [HW-1:0]     rd_head, wr_head;
  logic [FW-1:0]     rd_fill, wr_fill;
  logic [AW-1:0]     store_addr;
  logic [TASK_W-1:0] store_rdata;
  logic [MAX_WORKERS-1:0] nonempty;

  logic              rem_go, rem_done;
  logic [WID_W-1:0]  rem;

  logic              accept;
  status_t           acc_status;
  logic [CFG_DW-1:0] clamped;
  logic [FW:0]       slot_sum;
  logic [HW-1:0]     slot;
  logic [HW-1:0]     head_inc;
  logic              hit_hi, hit_any;
  logic [WID_W-1:0]  pos_hi, pos_any;
  logic [WI-1:0]     wid_idx;
  logic [31:0]       pend_ext;

  assign accept  = start && !busy;
  assign wid_idx = worker[WI-1:0];

  assign clamped = (cfg_data == '0) ? CFG_DW'(1) :
                   (cfg_data > MAXW) ? MAXW : cfg_data;

  // Push slot and pop head, both modulo the queue depth
  assign slot_sum = (FW+1)'(rd_head) + (FW+1)'(rd_fill);
  assign slot     = (slot_sum >= (FW+1)'(QUEUE_DEPTH)) ?
                    HW'(slot_sum - (FW+1)'(QUEUE_DEPTH)) : HW'(slot_sum);
  assign head_inc = (rd_head == HW'(QUEUE_DEPTH - 1)) ? '0 : rd_head + 1'b1;

  // First non-empty active queue at or after own, else the first one overall
  always_comb begin
    hit_hi  = 1'b0;
    hit_any = 1'b0;
    pos_hi  = '0;
    pos_any = '0;
    for (int i = MAX_WORKERS - 1; i >= 0; i--) begin
      if (nonempty[i] && (CNT_W'(i) < active_workers)) begin
        hit_any = 1'b1;
        pos_any = WID_W'(i);
        if (WID_W'(i) >= own) begin
          hit_hi = 1'b1;
          pos_hi = WID_W'(i);
        end
      end
    end
  end

  always_comb begin
    qctl = '0;
    qctl.meta_rd  = (state == S_META);
    qctl.meta_wr  = (state == S_CHK) && (rd_fill != '0 || cur_mode == MODE_SUBMIT)
                    && !(cur_mode == MODE_SUBMIT && rd_fill == FW'(QUEUE_DEPTH));
    qctl.store_wr = (state == S_CHK) && (cur_mode == MODE_SUBMIT)
                    && (rd_fill != FW'(QUEUE_DEPTH));
    qctl.store_rd = (state == S_CHK) && (cur_mode == MODE_TAKE);
    wr_head = (cur_mode == MODE_SUBMIT) ? rd_head : head_inc;
    wr_fill = (cur_mode == MODE_SUBMIT) ? rd_fill + 1'b1 : rd_fill - 1'b1;
    store_addr = AW'(target) * AW'(QUEUE_DEPTH) +
                 AW'((cur_mode == MODE_SUBMIT) ? slot : rd_head);
  end

  // Status known at accept for the items that finish at once
  always_comb begin
    acc_status = ST_NONE;
    unique case (mode)
      MODE_COMPLETE:  acc_status = ST_OK;
      MODE_BLK_BEGIN: if (CNT_W'(worker) < MAXW && !blocked_mark[wid_idx])
                        acc_status = ST_OK;
      MODE_BLK_END:   if (CNT_W'(worker) < MAXW && blocked_mark[wid_idx])
                        acc_status = ST_OK;
      default: ;
    endcase
  end

  assign rem_go = accept && (mode == MODE_TAKE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (mode == MODE_TAKE) state_next = S_REM;
          else if (mode == MODE_SUBMIT)   state_next = S_META;
          else                            state_next = S_DONE;
        end
      end
      S_REM:  if (rem_done) state_next = S_SCAN;
      S_SCAN: state_next = (hit_hi || hit_any) ? S_META : S_DONE;
      S_META: state_next = S_CHK;
      S_CHK:  state_next = (cur_mode == MODE_TAKE) ? S_DATA : S_DONE;
      S_DATA: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      pool_started    <= 1'b1;
      active_workers  <= RST_WORKERS;
      next_target     <= '0;
      pending_tasks   <= '0;
      busy_workers    <= '0;
      blocked_workers <= '0;
      blocked_mark    <= '0;
      completed_tasks <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_INIT_WORKERS: begin
            active_workers <= clamped;
            next_target    <= '0;
          end
          REG_POOL_STARTED: pool_started <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        unique case (mode)
          MODE_COMPLETE: begin
            if (busy_workers != '0) busy_workers <= busy_workers - 1'b1;
            completed_tasks <= completed_tasks + 1'b1;
          end
          MODE_BLK_BEGIN: begin
            if (CNT_W'(worker) < MAXW && !blocked_mark[wid_idx]) begin
              blocked_mark[wid_idx] <= 1'b1;
              if (blocked_workers < MAXW) blocked_workers <= blocked_workers + 1'b1;
            end
          end
          MODE_BLK_END: begin
            if (CNT_W'(worker) < MAXW && blocked_mark[wid_idx]) begin
              blocked_mark[wid_idx] <= 1'b0;
              if (blocked_workers != '0) blocked_workers <= blocked_workers - 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (state == S_CHK) begin
        if (cur_mode == MODE_SUBMIT) begin
          if (rd_fill != FW'(QUEUE_DEPTH)) begin
            next_target   <= (CNT_W'(next_target) + 1'b1 == active_workers) ?
                             '0 : next_target + 1'b1;
            pending_tasks <= pending_tasks + 1'b1;
            if (pool_started && blocked_workers != '0 && active_workers < MAXW)
              active_workers <= active_workers + 1'b1;
          end
        end else begin
          if (pending_tasks != '0) pending_tasks <= pending_tasks - 1'b1;
          if (busy_workers < MAXW) busy_workers <= busy_workers + 1'b1;
        end
      end
    end
  end

  // Item capture and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_mode     <= mode_t'(mode);
      cur_tid      <= task_id;
      target       <= next_target;
      task_out     <= '0;
      source_queue <= '0;
      stolen       <= 1'b0;
      spawned      <= 1'b0;
      status       <= acc_status;
    end
    if (rem_done) own <= rem;
    if (state == S_SCAN) begin
      target <= hit_hi ? pos_hi : pos_any;
      if (!(hit_hi || hit_any)) status <= ST_EMPTY;
    end
    if (state == S_CHK) begin
      source_queue <= target;
      if (cur_mode == MODE_SUBMIT) begin
        if (rd_fill == FW'(QUEUE_DEPTH)) begin
          status <= ST_FULL;
        end else begin
          status  <= ST_OK;
          spawned <= pool_started && blocked_workers != '0 && active_workers < MAXW;
        end
      end else begin
        status <= ST_OK;
        stolen <= (target != own);
      end
    end
    if (state == S_DATA) task_out <= store_rdata;
  end

  wsd_rem_unit u_rem (
    .clk      (clk),
    .rst      (rst),
    .go       (rem_go),
    .dividend (worker),
    .divisor  (active_workers),
    .done     (rem_done),
    .rem      (rem)
  );

  wsd_queues #(
    .MAX_WORKERS (MAX_WORKERS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queues (
    .clk         (clk),
    .rst         (rst),
    .ctl         (qctl),
    .meta_addr   (target[WI-1:0]),
    .wr_head     (wr_head),
    .wr_fill     (wr_fill),
    .store_addr  (store_addr),
    .store_wdata (cur_tid),
    .rd_head     (rd_head),
    .rd_fill     (rd_fill),
    .store_rdata (store_rdata),
    .nonempty    (nonempty)
  );

  assign busy            = (state != S_IDLE);
  assign done            = (state == S_DONE);
  assign pend_ext        = 32'(pending_tasks);
  assign pending_count   = pend_ext[10:0];
  assign busy_count      = busy_workers;
  assign blocked_count   = blocked_workers;
  assign worker_count    = active_workers;
  assign completed_count = completed_tasks;

  a_done_frees: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("dispatcher still busy after result");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");
  a_workers_range: assert property (@(posedge clk) disable iff (rst)
    (active_workers != '0) && (active_workers <= MAXW))
    else $error("active worker count out of range");
  a_target_range: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(next_target) < active_workers)
    else $error("round-robin pointer beyond active workers");
  a_take_scan: assert property (@(posedge clk) disable iff (rst)
    rem_done |=> (state == S_SCAN))
    else $error("remainder finished outside take sequence");

endmodule
